### rtl/core/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Types and constants shared by the double-ended queue, its checker and its testbench.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} deq_op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} deq_state_t;

	typedef struct packed {
		deq_op_t            operation;
		logic signed [31:0] value;
	} deq_cmd_t;

	typedef struct packed {
		logic signed [31:0]   front_value;
		logic signed [31:0]   back_value;
		logic [COUNT_W-1:0]   count;
		logic                 is_empty;
		deq_status_t          status;
	} deq_rsp_t;

endpackage
`default_nettype wire

### rtl/core/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr_a,
	output logic      [WIDTH-1:0]  rdata_a,
	input  wire logic [ADDR_W-1:0] raddr_b,
	output logic      [WIDTH-1:0]  rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

### rtl/core/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring RAM with front/back
// pointers and a count. One result transaction per command.
// Latency: result strobes in the cycle after the command is taken.
// A new command is taken only once the previous result has strobed;
// busy is high during the result cycle.
// The receiver cannot stall; reset clears pointers and count, RAM is not
// cleared (an empty result reports all ones, so unwritten entries never show).
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire deq_cmd_t cmd,
	output logic          strobe,
	output deq_rsp_t      rsp
);

	deq_state_t state_q, state_d;

	logic [IDX_W-1:0] front_q, back_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             full, empty;
	logic [IDX_W-1:0] nf, nb, waddr, back_last;
	logic [CNT_W-1:0] ncnt;
	logic             we;
	deq_status_t      status;

	logic              fwd_a_s1, fwd_b_s1, empty_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [CNT_W-1:0]  cnt_s1;
	deq_status_t       status_s1;
	logic [DATA_W-1:0] rdata_a, rdata_b;
	logic [31:0]       cnt_ext;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		ring_next = (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		ring_prev = (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	assign accept = start && !busy;
	assign full   = (cnt_q == CNT_W'(DEPTH));
	assign empty  = (cnt_q == '0);

	always_comb begin
		nf     = front_q;
		nb     = back_q;
		ncnt   = cnt_q;
		we     = 1'b0;
		waddr  = back_q;
		status = STAT_DONE;
		unique case (cmd.operation)
			OP_PUSH_BACK: begin
				if (full) begin
					status = STAT_FULL;
				end else begin
					we    = 1'b1;
					waddr = back_q;
					nb    = ring_next(back_q);
					ncnt  = cnt_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (full) begin
					status = STAT_FULL;
				end else begin
					we    = 1'b1;
					nf    = ring_prev(front_q);
					waddr = nf;
					ncnt  = cnt_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					nf   = ring_next(front_q);
					ncnt = cnt_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					status = STAT_EMPTY;
				end else begin
					nb   = ring_prev(back_q);
					ncnt = cnt_q - 1'b1;
				end
			end
		endcase
		back_last = ring_prev(nb);
	end

	deq_ram #(
		.DEPTH (DEPTH),
		.WIDTH (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (accept && we),
		.waddr   (waddr),
		.wdata   (cmd.value),
		.raddr_a (nf),
		.rdata_a (rdata_a),
		.raddr_b (back_last),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			back_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				front_q <= nf;
				back_q  <= nb;
				cnt_q   <= ncnt;
			end
		end
	end

	// write and reads share the accept edge; forward the pushed value
	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_a_s1  <= we && (waddr == nf);
			fwd_b_s1  <= we && (waddr == back_last);
			wdata_s1  <= cmd.value;
			cnt_s1    <= ncnt;
			empty_s1  <= (ncnt == '0);
			status_s1 <= status;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy   = 1'b0;
		strobe = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				strobe = 1'b0;
			end
			ST_RESP: begin
				busy   = 1'b1;
				strobe = 1'b1;
			end
		endcase
	end

	assign cnt_ext = 32'(cnt_s1);

	always_comb begin
		rsp.front_value = empty_s1 ? '1 : (fwd_a_s1 ? wdata_s1 : rdata_a);
		rsp.back_value  = empty_s1 ? '1 : (fwd_b_s1 ? wdata_s1 : rdata_b);
		rsp.count       = cnt_ext[COUNT_W-1:0];
		rsp.is_empty    = empty_s1;
		rsp.status      = status_s1;
	end

endmodule
`default_nettype wire

### bench/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Watches the command and result channels of the double-ended queue. It keeps
// its own ring, pointers and count, predicts the result of every accepted
// command, and compares each strobed result, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module deq_checker
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  deq_cmd_t cmd,
	input  logic     strobe,
	input  deq_rsp_t rsp,
	output int       fails,
	output int       pending
);

	logic [DATA_W-1:0] ring [DEPTH];
	int                head_idx;
	int                tail_idx;
	int                fill;
	deq_rsp_t          pending_rsp_q [$];

	function automatic deq_rsp_t rsp_after_cmd(deq_cmd_t c);
		deq_rsp_t r;
		r.status = STAT_DONE;
		case (c.operation)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					r.status = STAT_FULL;
				end else if (c.operation == OP_PUSH_BACK) begin
					ring[tail_idx] = c.value;
					tail_idx       = (tail_idx + 1) % DEPTH;
					fill++;
				end else begin
					head_idx       = (head_idx + DEPTH - 1) % DEPTH;
					ring[head_idx] = c.value;
					fill++;
				end
			end
			default: begin
				if (fill == 0) begin
					r.status = STAT_EMPTY;
				end else if (c.operation == OP_POP_FRONT) begin
					head_idx = (head_idx + 1) % DEPTH;
					fill--;
				end else begin
					tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
					fill--;
				end
			end
		endcase
		r.front_value = (fill != 0) ? ring[head_idx] : '1;
		r.back_value  = (fill != 0) ? ring[(tail_idx + DEPTH - 1) % DEPTH] : '1;
		r.count       = COUNT_W'(fill);
		r.is_empty    = (fill == 0);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deq_rsp_t exp_rsp;
		int       errs;
		errs = 0;
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			fill     = 0;
			pending_rsp_q.delete();
			pending  <= 0;
			fails    <= 0;
		end else begin
			if (strobe) begin
				if (pending_rsp_q.size() == 0) begin
					$error("result transaction with no command outstanding");
					errs++;
				end else begin
					exp_rsp = pending_rsp_q.pop_front();
					if (rsp.front_value !== exp_rsp.front_value) begin
						$error("front_value: expected %0d, got %0d",
							exp_rsp.front_value, rsp.front_value);
						errs++;
					end
					if (rsp.back_value !== exp_rsp.back_value) begin
						$error("back_value: expected %0d, got %0d",
							exp_rsp.back_value, rsp.back_value);
						errs++;
					end
					if (rsp.count !== exp_rsp.count) begin
						$error("count: expected %0d, got %0d", exp_rsp.count, rsp.count);
						errs++;
					end
					if (rsp.is_empty !== exp_rsp.is_empty) begin
						$error("is_empty: expected %0d, got %0d",
							exp_rsp.is_empty, rsp.is_empty);
						errs++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						errs++;
					end
				end
			end
			if (errs != 0) begin
				fails <= fails + errs;
			end
			if (start && !busy) begin
				pending_rsp_q.push_back(rsp_after_cmd(cmd));
			end
			pending <= pending_rsp_q.size();
		end
	end

endmodule

### bench/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives the double-ended queue with a directed opening (pops on empty,
// extreme values, filling to full, pushes on full) and then random command
// streams biased at random toward filling, draining or balance, under several idling
// phases. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int ITEMS_PER_PHASE = 475;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	deq_cmd_t cmd;
	logic     strobe;
	deq_rsp_t rsp;
	int       fails;
	int       pending;

	double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.strobe (strobe),
		.rsp    (rsp)
	);

	deq_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.strobe  (strobe),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// returns at the edge where the transaction is taken
	task automatic issue_cmd(input deq_op_t op, input logic [DATA_W-1:0] v);
		deq_cmd_t c;
		c.operation = op;
		c.value     = v;
		start <= 1'b1;
		cmd   <= c;
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int idle_pct [4];
		int push_pct;
		deq_op_t op;
		idle_pct = '{0, 77, 0, 29};
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue_cmd(OP_POP_FRONT, $urandom());
		issue_cmd(OP_POP_BACK, $urandom());
		issue_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
		issue_cmd(OP_PUSH_FRONT, 32'h8000_0000);
		issue_cmd(OP_POP_BACK, $urandom());
		issue_cmd(OP_POP_FRONT, $urandom());
		issue_cmd(OP_PUSH_BACK, 32'h0000_0000);
		issue_cmd(OP_PUSH_FRONT, 32'hffff_ffff);
		for (int i = 2; i < DEPTH; i++)
			issue_cmd((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom());
		issue_cmd(OP_PUSH_BACK, $urandom());
		issue_cmd(OP_PUSH_FRONT, $urandom());
		issue_cmd(OP_POP_BACK, $urandom());
		issue_cmd(OP_POP_FRONT, $urandom());

		push_pct = 50;
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// swing between filling, draining and balanced streams
				if (n % 48 == 0) begin
					case ($urandom_range(2))
						0:       push_pct = 15;
						1:       push_pct = 50;
						default: push_pct = 85;
					endcase
				end
				if ($urandom_range(99) < push_pct)
					op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
				if ($urandom_range(99) < idle_pct[ph]) begin
					start <= 1'b0;
					@(posedge clk);
					while ($urandom_range(99) < idle_pct[ph]) @(posedge clk);
				end
				issue_cmd(op, pick_value());
			end
		end
		start <= 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
		@(negedge clk);
		if (fails == 0) begin
			$display("tb_double_ended_queue passed");
		end else begin
			$display("tb_double_ended_queue failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_double_ended_queue failed");
		$finish;
	end

endmodule
